/* hw/rtl/pmm_pkg.sv */
`default_nettype none

package pmm_pkg;

  localparam int unsigned PAGE_BYTES         = 256;
  localparam int unsigned PAGE_TOTAL         = 64;
  localparam int unsigned TABLE_POINTER_BASE = 64;

  localparam int unsigned ENTRY_COUNT = (PAGE_TOTAL < PAGE_BYTES) ? PAGE_TOTAL : PAGE_BYTES;
  localparam int unsigned MEM_BYTES   = PAGE_BYTES * PAGE_TOTAL;

  localparam int unsigned OFF_W  = $clog2(PAGE_BYTES);
  localparam int unsigned PG_W   = $clog2(PAGE_TOTAL);
  localparam int unsigned AW     = OFF_W + PG_W;
  localparam int unsigned ENT_W  = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned DATA_W = 8;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PROC_W   = 8;
  localparam int unsigned WANT_W   = 7;
  localparam int unsigned VA_W     = 14;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MISS_W   = 7;
  localparam int unsigned PA_W     = 14;
  localparam int unsigned VPG_W    = VA_W - OFF_W;

  localparam logic [MODE_W-1:0] MODE_NEW   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KILL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STORE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_TABLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PROC_W-1:0] process;
    logic [WANT_W-1:0] pages_wanted;
    logic [VA_W-1:0]   virtual_address;
    logic [DATA_W-1:0] store_data;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MISS_W-1:0]   pages_missing;
    logic [PA_W-1:0]     physical_address;
    logic [DATA_W-1:0]   load_data;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/paged_memory_manager_top.sv */
// Channel   Ports                       Transfer
// request   start, busy, req_i          start high and busy low at a rising edge
// result    res_valid_o, res_o          res_valid_o high for one cycle, always taken
//
// Every step goes through one single-port memory with a registered read, one access a cycle.
// Load reads the pointer, the table entry and the data byte; store writes the data byte instead.
// Kill clears each entry and frees its page, then frees the table page and clears the pointer.
// New process scans up to PAGE_TOTAL - 1 map bytes, clears the table page, sets pointer and entries.
// After reset a sweep over all MEM_BYTES bytes (16384) loads the reset image; busy stays high.
// The result port has no back-pressure; a new request is taken while a result is shown.
`default_nettype none

module paged_memory_manager_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire pmm_pkg::req_t req_i,
  output logic               res_valid_o,
  output pmm_pkg::res_t      res_o
);

  import pmm_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_N_RD   = 4'd2;
  localparam logic [3:0] S_N_CHK  = 4'd3;
  localparam logic [3:0] S_N_ZERO = 4'd4;
  localparam logic [3:0] S_N_PTR  = 4'd5;
  localparam logic [3:0] S_N_ENT  = 4'd6;
  localparam logic [3:0] S_K_TBL  = 4'd7;
  localparam logic [3:0] S_K_RD   = 4'd8;
  localparam logic [3:0] S_K_CHK  = 4'd9;
  localparam logic [3:0] S_K_CLRE = 4'd10;
  localparam logic [3:0] S_K_FREE = 4'd11;
  localparam logic [3:0] S_K_PTR  = 4'd12;
  localparam logic [3:0] S_T_TBL  = 4'd13;
  localparam logic [3:0] S_T_ENT  = 4'd14;
  localparam logic [3:0] S_T_LD   = 4'd15;

  localparam logic [PG_W-1:0]  LAST_PAGE = PG_W'(PAGE_TOTAL - 1);
  localparam logic [ENT_W-1:0] LAST_ENT  = ENT_W'(ENTRY_COUNT - 1);

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [PG_W-1:0]   scan_q, scan_d;
  logic [PG_W-1:0]   tbl_q, tbl_d;
  logic              have_tbl_q, have_tbl_d;
  logic [ENT_W-1:0]  ent_q, ent_d;
  logic [ENT_W-1:0]  wanted_q, wanted_d;
  logic [AW-1:0]     paddr_q, paddr_d;
  req_t              req_q, req_d;
  res_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  logic              accept;
  logic [OFF_W-1:0]  ptr_in_off;
  logic [OFF_W-1:0]  ptr_off;
  logic [VPG_W-1:0]  vpage;
  logic [OFF_W-1:0]  voff;
  logic              vpage_ok;
  logic              rd_valid_page;
  logic [ENT_W-1:0]  ent_inc;
  logic [AW-1:0]     phys_addr;

  function automatic logic page_ok(logic [DATA_W-1:0] d);
    return (d != '0) && (32'(d) < 32'(PAGE_TOTAL));
  endfunction

  function automatic res_t new_res(logic tbl, logic [ENT_W-1:0] want, logic [ENT_W-1:0] got);
    res_t r;
    logic [ENT_W-1:0] miss;
    miss = want - got;
    r = '0;
    r.pages_missing = MISS_W'(miss);
    if (!tbl) begin
      r.status = STATUS_NO_TABLE;
    end else if (miss != '0) begin
      r.status = STATUS_MISSING;
    end else begin
      r.status = STATUS_OK;
    end
    return r;
  endfunction

  pmm_ram #(
    .Width(DATA_W),
    .Depth(MEM_BYTES)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign accept        = start && !busy;
  assign ptr_in_off    = OFF_W'(32'(TABLE_POINTER_BASE) + 32'(req_i.process));
  assign ptr_off       = OFF_W'(32'(TABLE_POINTER_BASE) + 32'(req_q.process));
  assign vpage         = req_q.virtual_address[VA_W-1:OFF_W];
  assign voff          = req_q.virtual_address[OFF_W-1:0];
  assign vpage_ok      = 32'(vpage) < 32'(ENTRY_COUNT);
  assign rd_valid_page = page_ok(mem_rdata);
  assign ent_inc       = ent_q + ENT_W'(1);
  assign phys_addr     = {PG_W'(mem_rdata), voff};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    tbl_d       = tbl_q;
    have_tbl_d  = have_tbl_q;
    ent_d       = ent_q;
    wanted_d    = wanted_q;
    paddr_d     = paddr_q;
    req_d       = req_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = AW'(ptr_off);
    mem_wdata   = '0;

    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = cnt_q;
        mem_wdata = (cnt_q == '0) ? DATA_W'(1) : '0;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(MEM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_addr = AW'(ptr_in_off);
        if (accept) begin
          req_d      = req_i;
          scan_d     = PG_W'(1);
          have_tbl_d = 1'b0;
          ent_d      = '0;
          wanted_d   = (32'(req_i.pages_wanted) > 32'(ENTRY_COUNT)) ?
                       ENT_W'(ENTRY_COUNT) : ENT_W'(req_i.pages_wanted);
          unique case (req_i.mode)
            MODE_NEW:   state_d = S_N_RD;
            MODE_KILL:  state_d = S_K_TBL;
            MODE_STORE: state_d = S_T_TBL;
            MODE_LOAD:  state_d = S_T_TBL;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_N_RD: begin
        mem_addr = AW'(scan_q);
        state_d  = S_N_CHK;
      end
      S_N_CHK: begin
        mem_addr = AW'(scan_q);
        if (mem_rdata == '0) begin
          mem_we    = 1'b1;
          mem_wdata = DATA_W'(1);
          if (!have_tbl_q) begin
            tbl_d      = scan_q;
            have_tbl_d = 1'b1;
            cnt_d      = '0;
            state_d    = S_N_ZERO;
          end else begin
            state_d = S_N_ENT;
          end
        end else if (scan_q == LAST_PAGE) begin
          res_d       = new_res(have_tbl_q, wanted_q, ent_q);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          scan_d  = scan_q + PG_W'(1);
          state_d = S_N_RD;
        end
      end
      S_N_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = {tbl_q, cnt_q[OFF_W-1:0]};
        cnt_d    = cnt_q + AW'(1);
        if (cnt_q[OFF_W-1:0] == '1) begin
          state_d = S_N_PTR;
        end
      end
      S_N_PTR: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(ptr_off);
        mem_wdata = DATA_W'(tbl_q);
        if (wanted_q == '0 || scan_q == LAST_PAGE) begin
          res_d       = new_res(1'b1, wanted_q, ent_q);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          scan_d  = scan_q + PG_W'(1);
          state_d = S_N_RD;
        end
      end
      S_N_ENT: begin
        mem_we    = 1'b1;
        mem_addr  = {tbl_q, OFF_W'(ent_q)};
        mem_wdata = DATA_W'(scan_q);
        ent_d     = ent_inc;
        if (ent_inc == wanted_q || scan_q == LAST_PAGE) begin
          res_d       = new_res(1'b1, wanted_q, ent_inc);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          scan_d  = scan_q + PG_W'(1);
          state_d = S_N_RD;
        end
      end
      S_K_TBL: begin
        if (rd_valid_page) begin
          tbl_d   = PG_W'(mem_rdata);
          ent_d   = '0;
          state_d = S_K_RD;
        end else begin
          res_d       = '0;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_K_RD: begin
        mem_addr = {tbl_q, OFF_W'(ent_q)};
        state_d  = S_K_CHK;
      end
      S_K_CHK: begin
        mem_addr = AW'(mem_rdata);
        mem_we   = rd_valid_page;
        state_d  = S_K_CLRE;
      end
      S_K_CLRE: begin
        mem_we   = 1'b1;
        mem_addr = {tbl_q, OFF_W'(ent_q)};
        if (ent_q == LAST_ENT) begin
          state_d = S_K_FREE;
        end else begin
          ent_d   = ent_inc;
          state_d = S_K_RD;
        end
      end
      S_K_FREE: begin
        mem_we   = 1'b1;
        mem_addr = AW'(tbl_q);
        state_d  = S_K_PTR;
      end
      S_K_PTR: begin
        mem_we      = 1'b1;
        mem_addr    = AW'(ptr_off);
        res_d       = '0;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_T_TBL: begin
        mem_addr = {PG_W'(mem_rdata), OFF_W'(vpage)};
        if (rd_valid_page && vpage_ok) begin
          state_d = S_T_ENT;
        end else begin
          res_d       = '0;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_T_ENT: begin
        mem_addr  = phys_addr;
        mem_wdata = req_q.store_data;
        paddr_d   = phys_addr;
        if (!rd_valid_page) begin
          res_d       = '0;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (req_q.mode == MODE_STORE) begin
          mem_we                 = 1'b1;
          res_d                  = '0;
          res_d.physical_address = PA_W'(phys_addr);
          res_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end else begin
          state_d = S_T_LD;
        end
      end
      S_T_LD: begin
        res_d                  = '0;
        res_d.physical_address = PA_W'(paddr_q);
        res_d.load_data        = mem_rdata;
        res_valid_d            = 1'b1;
        state_d                = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      scan_q      <= '0;
      have_tbl_q  <= 1'b0;
      ent_q       <= '0;
      wanted_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      have_tbl_q  <= have_tbl_d;
      ent_q       <= ent_d;
      wanted_q    <= wanted_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_q   <= tbl_d;
    paddr_q <= paddr_d;
    req_q   <= req_d;
    res_q   <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("request taken but sequencer did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> !busy)
    else $error("result shown while sequencer still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |=> !res_valid_o)
    else $error("two results in consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_OK |->
      res_o.physical_address == '0 && res_o.load_data == '0)
    else $error("allocation result carries translation fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == STATUS_OK && res_o.pages_missing != '0 |-> 1'b0)
    else $error("missing pages reported with ok status");

endmodule

`default_nettype wire

/* hw/rtl/pmm_ram.sv */
`default_nettype none

module pmm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
